>>> rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by every module under rtl/core but the checker.

package u8u16_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

  localparam logic [10:0] MIN_CP2    = 11'h080;
  localparam logic [15:0] MIN_CP3    = 16'h0800;
  localparam logic [15:0] SURR_FIRST = 16'hD800;
  localparam logic [15:0] SURR_LAST  = 16'hDFFF;
  localparam logic [21:0] MIN_CP4    = 22'h010000;
  localparam logic [21:0] MAX_CP     = 22'h10FFFF;

  // One byte's worth of results: nbad replacement units, then ngood units.
  typedef struct packed {
    logic [2:0]  nbad;
    logic [1:0]  ngood;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        eos;
  } desc_t;

endpackage

>>> rtl/core/u8u16_front.sv
// Front end: accepts UTF-8 bytes, holds partial sequences, and turns each
// byte that yields units into one result descriptor. Depends on u8u16_pkg.

module u8u16_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               eos_i,
  output logic               push_o,
  input  logic               full_i,
  output u8u16_pkg::desc_t   desc_o
);

  logic [7:0]  held_q [3];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [2:0]  held_we;
  logic        accept;
  logic        is_cont;
  logic        fresh;
  logic        need_more;
  logic [2:0]  seq_len;
  logic [2:0]  nbad;
  logic [1:0]  ngood;
  logic [15:0] u0, u1;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [21:0] cp4;
  logic [21:0] cp4_off;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !full_i;
  assign is_cont    = (data_byte_i[7:6] == 2'b10);

  assign seq_len = (held_q[0] >= 8'hF0) ? 3'd4 : (held_q[0] >= 8'hE0) ? 3'd3 : 3'd2;
  assign need_more = (({1'b0, held_cnt_q} + 3'd1) < seq_len) && (held_cnt_q != 2'd3);

  assign cp2 = {held_q[0][4:0], data_byte_i[5:0]};
  assign cp3 = {held_q[0][3:0], held_q[1][5:0], data_byte_i[5:0]};
  assign cp4 = {held_q[0][3:0], held_q[1][5:0], held_q[2][5:0], data_byte_i[5:0]};
  assign cp4_off = cp4 - u8u16_pkg::MIN_CP4;

  always_comb begin
    nbad       = 3'd0;
    ngood      = 2'd0;
    u0         = '0;
    u1         = '0;
    held_cnt_d = held_cnt_q;
    held_we    = 3'b000;
    fresh      = 1'b0;
    if (held_cnt_q == 2'd0) begin
      fresh = 1'b1;
    end else if (!is_cont) begin
      // broken sequence: replace every held byte, restart on this one
      nbad       = {1'b0, held_cnt_q};
      held_cnt_d = 2'd0;
      fresh      = 1'b1;
    end else if (need_more) begin
      held_we[held_cnt_q] = 1'b1;
      held_cnt_d          = held_cnt_q + 2'd1;
    end else begin
      held_cnt_d = 2'd0;
      case (held_cnt_q)
        2'd1: begin
          if (cp2 >= u8u16_pkg::MIN_CP2) begin
            ngood = 2'd1;
            u0    = {5'd0, cp2};
          end else begin
            nbad = 3'd2;
          end
        end
        2'd2: begin
          if (cp3 >= u8u16_pkg::MIN_CP3 &&
              !(cp3 >= u8u16_pkg::SURR_FIRST && cp3 <= u8u16_pkg::SURR_LAST)) begin
            ngood = 2'd1;
            u0    = cp3;
          end else begin
            nbad = 3'd3;
          end
        end
        default: begin
          if (cp4 >= u8u16_pkg::MIN_CP4 && cp4 <= u8u16_pkg::MAX_CP) begin
            ngood = 2'd2;
            u0    = {u8u16_pkg::HI_SURR_TAG, cp4_off[19:10]};
            u1    = {u8u16_pkg::LO_SURR_TAG, cp4_off[9:0]};
          end else begin
            nbad = 3'd4;
          end
        end
      endcase
    end
    if (fresh) begin
      if (!data_byte_i[7]) begin
        ngood = 2'd1;
        u0    = {8'h00, data_byte_i};
      end else if (!data_byte_i[6]) begin
        nbad = nbad + 3'd1;
      end else begin
        held_we[0] = 1'b1;
        held_cnt_d = 2'd1;
      end
    end
    // end of string: flush whatever is still held
    if (eos_i) begin
      nbad       = nbad + {1'b0, held_cnt_d};
      held_cnt_d = 2'd0;
    end
  end

  assign desc_o.nbad  = nbad;
  assign desc_o.ngood = ngood;
  assign desc_o.unit0 = u0;
  assign desc_o.unit1 = u1;
  assign desc_o.eos   = eos_i;
  assign push_o       = accept && ((nbad != 3'd0) || (ngood != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && held_we[i]) begin
        held_q[i] <= data_byte_i;
      end
    end
  end

endmodule

>>> rtl/core/u8u16_fifo.sv
// Short descriptor queue between front and back end.
// Depends on u8u16_pkg.

module u8u16_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8u16_pkg::desc_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output u8u16_pkg::desc_t rdata_o
);

  u8u16_pkg::desc_t                 mem_q [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [u8u16_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/u8u16_back.sv
// Back end: expands one descriptor into code units, one per cycle unless
// the output stalls, into a registered output stage. Depends on u8u16_pkg.

module u8u16_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  u8u16_pkg::desc_t desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [15:0]      code_unit_o,
  output logic             replaced_o,
  output logic             last_of_run_o,
  output logic             last_of_string_o
);

  logic [1:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic [15:0] unit_q;
  logic        repl_q, lrun_q, lstr_q;
  logic        emit;
  logic [2:0]  total;
  logic [2:0]  good_sel;
  logic        is_bad;
  logic        is_last;
  logic [15:0] cur_unit;

  assign total    = desc_i.nbad + {1'b0, desc_i.ngood};
  assign is_bad   = ({1'b0, idx_q} < desc_i.nbad);
  assign good_sel = {1'b0, idx_q} - desc_i.nbad;
  assign is_last  = (({1'b0, idx_q} + 3'd1) == total);
  assign cur_unit = is_bad ? u8u16_pkg::REPL_UNIT :
                    (good_sel[0] ? desc_i.unit1 : desc_i.unit0);

  assign emit  = valid_i && (!vld_q || out_ready_i);
  assign pop_o = emit && is_last;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
    if (emit) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      unit_q <= cur_unit;
      repl_q <= is_bad;
      lrun_q <= is_last;
      lstr_q <= is_last && desc_i.eos;
    end
  end

  assign out_valid_o      = vld_q;
  assign code_unit_o      = unit_q;
  assign replaced_o       = repl_q;
  assign last_of_run_o    = lrun_q;
  assign last_of_string_o = lstr_q;

endmodule

>>> rtl/core/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder, top level.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
//
// Usage:
//   Slave stream: one UTF-8 byte per transaction in s_axis_tdata_i, with
//   s_axis_tlast_i marking the final byte of a string (held bytes flush).
//   Master stream: one UTF-16 code unit per transaction. tlast marks the
//   last unit caused by one input byte; tuser[0] flags a U+FFFD
//   replacement and tuser[1] marks the final unit of the string.
//   A byte that only extends a held sequence produces no transaction.
// Throughput: one byte per cycle while each byte yields at most one unit
//   and tready is high. A byte yields up to four units (replacement bursts,
//   surrogate pairs); the back end drains one unit per cycle while tready
//   is high, and the four-entry descriptor queue between front and back
//   absorbs the burst before input stalls.
// Path: each byte's descriptor is queued, then its units are registered.
// Reset: rst_ni clears held count, queue and output valid; no clearing
//   pass is needed. When the receiver deasserts tready the output unit
//   holds, the queue fills, and then s_axis_tready_o drops.

module utf8_to_utf16_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser_o,   // [0] replaced, [1] last_of_string
  output logic        m_axis_tlast_o    // last_of_run
);

  u8u16_pkg::desc_t push_desc, head_desc;
  logic             push, full, head_valid, pop;
  logic             repl, lstr;

  // Front: classify bytes, track the held sequence, build descriptors.
  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .data_byte_i (s_axis_tdata_i),
    .eos_i       (s_axis_tlast_i),
    .push_o      (push),
    .full_i      (full),
    .desc_o      (push_desc)
  );

  // Queue: decouple the byte side from the unit side.
  u8u16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_desc)
  );

  // Back: expand each descriptor into units behind an output register.
  u8u16_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (head_valid),
    .desc_i           (head_desc),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .code_unit_o      (m_axis_tdata_o),
    .replaced_o       (repl),
    .last_of_run_o    (m_axis_tlast_o),
    .last_of_string_o (lstr)
  );

  assign m_axis_tuser_o = {lstr, repl};

endmodule

>>> rtl/core/u8u16_checker.sv
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top.
// Depends on utf8_to_utf16_transcoder port names only.

module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // The end of a string is always the end of a run.
  a_str_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o)
    else $error("last_of_string without last_of_run");

  // Replacements always carry U+FFFD.
  a_repl_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 16'hFFFD)
    else $error("replacement unit is not U+FFFD");

  // A decoded high surrogate is followed by its low half in the same run.
  a_pair_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] && m_axis_tdata_o[15:10] == 6'b110110
      |-> !m_axis_tlast_o)
    else $error("high surrogate ends a run");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for utf8_to_utf16_transcoder: directed UTF-8 cases, then random text.
// Depends on u8u16_pkg and the transcoder RTL; carries its own UTF-16 predictor and checker.

module tb_top;

  localparam int unsigned MAX_UNITS_PER_BYTE = 4;
  localparam int unsigned STALL_LIMIT        = 2000;
  localparam int unsigned IDLE_PERCENT       = 9;
  localparam int unsigned DRAIN_CYCLES       = 8;

  // One expected or observed UTF-16 transaction on the master side.
  typedef struct packed {
    logic [15:0] code;
    logic        replaced;
    logic        run_last;
    logic        str_last;
  } utf16_unit_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Predictor state: the bytes of a partial sequence and how many are held.
  logic [7:0]  held_q [0:2];
  int unsigned held_n = 0;

  utf16_unit_t expected_units [$];  // units still owed by the block, oldest first
  utf16_unit_t byte_units [$];      // units caused by the byte being decoded
  logic [7:0]  text_bytes [$];      // encoded random string waiting to be sent

  bit          no_idle        = 1'b0;
  int unsigned errors         = 0;
  int unsigned bytes_sent     = 0;
  int unsigned strings_sent   = 0;
  int unsigned units_checked  = 0;
  int unsigned repl_seen      = 0;
  int unsigned surr_halves    = 0;
  int unsigned stall_cycles   = 0;

  utf8_to_utf16_transcoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // UTF-16 predictor
  // ---------------------------------------------------------------------------

  // Queue one unit for the current byte; the block never emits more than four.
  function automatic void emit_unit(input logic [15:0] code, input logic replaced);
    utf16_unit_t u;
    if (byte_units.size() < MAX_UNITS_PER_BYTE) begin
      u.code     = code;
      u.replaced = replaced;
      u.run_last = 1'b0;
      u.str_last = 1'b0;
      byte_units.push_back(u);
    end
  endfunction

  function automatic void emit_replacements(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) emit_unit(u8u16_pkg::REPL_UNIT, 1'b1);
  endfunction

  // Sequence length implied by a lead byte; leads from 0xF8 up count as four.
  function automatic int unsigned utf8_len(input logic [7:0] lead);
    if (lead >= 8'hF0) return 4;
    if (lead >= 8'hE0) return 3;
    return 2;
  endfunction

  // A byte seen with nothing held: ASCII passes, a stray continuation is
  // replaced, anything else opens a new sequence.
  function automatic void start_char(input logic [7:0] b);
    if (b < 8'h80) begin
      emit_unit({8'h00, b}, 1'b0);
    end else if (b < 8'hC0) begin
      emit_replacements(1);
    end else begin
      held_q[0] = b;
      held_n    = 1;
    end
  endfunction

  // The final continuation byte has arrived: assemble the code point, reject
  // overlong forms, surrogates and values past U+10FFFF, split those above U+FFFF.
  function automatic void close_sequence(input logic [7:0] last);
    int unsigned n;
    logic [21:0] cp;
    logic        ok;
    n      = held_n;
    held_n = 0;
    case (n)
      1: begin
        cp = {11'd0, held_q[0][4:0], last[5:0]};
        ok = (cp >= u8u16_pkg::MIN_CP2);
      end
      2: begin
        cp = {6'd0, held_q[0][3:0], held_q[1][5:0], last[5:0]};
        ok = (cp >= u8u16_pkg::MIN_CP3) &&
             !((cp >= u8u16_pkg::SURR_FIRST) && (cp <= u8u16_pkg::SURR_LAST));
      end
      default: begin
        cp = {held_q[0][3:0], held_q[1][5:0], held_q[2][5:0], last[5:0]};
        ok = (cp >= u8u16_pkg::MIN_CP4) && (cp <= u8u16_pkg::MAX_CP);
      end
    endcase
    if (!ok) begin
      emit_replacements(n + 1);
    end else if (cp >= u8u16_pkg::MIN_CP4) begin
      cp = cp - u8u16_pkg::MIN_CP4;
      emit_unit({u8u16_pkg::HI_SURR_TAG, cp[19:10]}, 1'b0);
      emit_unit({u8u16_pkg::LO_SURR_TAG, cp[9:0]}, 1'b0);
    end else begin
      emit_unit(cp[15:0], 1'b0);
    end
  endfunction

  // Advance the predictor by one accepted byte and append what it owes.
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    utf16_unit_t tail;
    byte_units.delete();
    if (held_n == 0) begin
      start_char(b);
    end else if (b[7:6] != 2'b10) begin
      // Broken sequence: replace every held byte, then restart on this one.
      emit_replacements(held_n);
      held_n = 0;
      start_char(b);
    end else if (held_n + 1 < utf8_len(held_q[0])) begin
      held_q[held_n] = b;
      held_n++;
    end else begin
      close_sequence(b);
    end
    if (eos) begin
      // Flush whatever is still held at the end of the string.
      emit_replacements(held_n);
      held_n = 0;
    end
    if (byte_units.size() != 0) begin
      tail          = byte_units.pop_back();
      tail.run_last = 1'b1;
      tail.str_last = eos;
      byte_units.push_back(tail);
    end
    foreach (byte_units[i]) expected_units.push_back(byte_units[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Random UTF-8 text
  // ---------------------------------------------------------------------------

  // Encode cp with exactly len bytes, overlong or out of range if asked.
  function automatic void append_coded(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // A code point that is legal in its shortest form of len bytes.
  function automatic int unsigned legal_cp(input int unsigned len);
    int unsigned cp;
    case (len)
      1: cp = $urandom_range(0, 'h7F);
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 'hD800) cp += 'h800;  // skip the surrogate block
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  // Mostly well-formed characters, with about a quarter noise and breakage.
  function automatic void append_random_char();
    int unsigned pick;
    int unsigned len;
    int unsigned top;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      len = (pick < 20) ? 1 : (pick < 35) ? 2 : (pick < 55) ? 3 : 4;
      append_coded(21'(legal_cp(len)), len);
    end else if (pick < 76) begin
      text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (pick < 80) begin
      len = $urandom_range(2, 4);
      top = (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF;
      append_coded(21'($urandom_range(0, top)), len);
    end else if (pick < 83) begin
      append_coded(21'($urandom_range('hD800, 'hDFFF)), 3);
    end else if (pick < 86) begin
      append_coded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else if (pick < 89) begin
      text_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
      repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (pick < 95) begin
      // Truncated sequence: drop one or more trailing bytes.
      len = $urandom_range(2, 4);
      append_coded(21'(legal_cp(len)), len);
      repeat ($urandom_range(1, len - 1)) text_bytes.delete(text_bytes.size() - 1);
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: one byte per transaction
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until accepted, then predict its units.
  // Leave tvalid high afterwards so back-to-back bytes need no second write.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_text();
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) append_random_char();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    strings_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random backpressure and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare every accepted unit against the oldest prediction.
  always @(posedge clk_i) begin
    utf16_unit_t exp_u;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_units.size() == 0) begin
        errors++;
        $display("%0t: unexpected unit: expected none, got code=%h repl=%b",
                 $time, m_axis_tdata_o, m_axis_tuser_o[0],
                 " run_last=%b str_last=%b", m_axis_tlast_o, m_axis_tuser_o[1]);
      end else begin
        exp_u = expected_units.pop_front();
        units_checked++;
        if (m_axis_tuser_o[0] === 1'b1) repl_seen++;
        else if (m_axis_tdata_o[15:11] === 5'b11011) surr_halves++;
        if (m_axis_tdata_o !== exp_u.code || m_axis_tuser_o[0] !== exp_u.replaced ||
            m_axis_tlast_o !== exp_u.run_last || m_axis_tuser_o[1] !== exp_u.str_last) begin
          errors++;
          $display("%0t: unit mismatch: expected code=%h repl=%b run_last=%b str_last=%b,",
                   $time, exp_u.code, exp_u.replaced, exp_u.run_last, exp_u.str_last,
                   " got code=%h repl=%b run_last=%b str_last=%b",
                   m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tlast_o, m_axis_tuser_o[1]);
        end
      end
    end
  end

  // Abort if neither side completes a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d units outstanding",
               $time, stall_cycles, expected_units.size());
      $display("** utf8_to_utf16_transcoder: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_single_byte();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_two_byte();
    send_byte(8'hC2, 1'b0);  // U+0080, smallest two-byte value
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_stray_continuation();
    send_byte(8'hBF, 1'b1);
  endtask

  // A lead and one continuation broken by ASCII: two replacements, then 'A'.
  task automatic test_broken_sequence();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_overlong();
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_surrogate_value();
    send_byte(8'hED, 1'b0);  // U+D800 encoded directly
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_above_max();
    send_byte(8'hF4, 1'b0);  // U+110000
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // An 0xFF lead with two continuations, broken by a new lead that is then
  // flushed at the end of the string: four replacements from one byte.
  task automatic test_flush_at_end();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC2, 1'b1);
  endtask

  task automatic test_surrogate_pair();
    send_byte(8'hF4, 1'b0);  // U+10FFFF, largest legal value
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_random_text(input int unsigned count, input bit steady);
    int unsigned start;
    start = bytes_sent;
    no_idle <= steady;
    while (bytes_sent - start < count) send_text();
    no_idle <= 1'b0;
  endtask

  // Drop valid and hold off until every owed unit has drained.
  task automatic test_drain_pause();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_units.size() != 0);
    send_text();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte();
    test_two_byte();
    test_stray_continuation();
    test_broken_sequence();
    test_overlong();
    test_surrogate_value();
    test_above_max();
    test_flush_at_end();
    test_surrogate_pair();
    test_random_text(35, 1'b1);
    test_drain_pause();
    test_random_text(55, 1'b0);

    // Stop sending, let the queue drain, then give stray units time to show.
    s_axis_tvalid_i <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d units",
             bytes_sent, strings_sent + 9, units_checked,
             " (%0d replacements, %0d surrogate halves)", repl_seen, surr_halves);
    if (errors == 0) begin
      $display("** utf8_to_utf16_transcoder: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** utf8_to_utf16_transcoder: FAILED **");
    end
    $finish;
  end

endmodule
